// ----- sv/lsr_pkg.sv -----
// Shared types, constants and arithmetic step functions of the level-set reinit step core.
`default_nettype none
package lsr_pkg;

  localparam int VAL_W  = 24;
  localparam int TS_W   = 16;
  localparam int SQ_W   = 52;
  localparam int RT_W   = 26;
  localparam int Q_W    = 17;
  localparam int SQRT_STEPS = 26;
  localparam int DIV_STEPS  = 17;
  localparam logic [TS_W-1:0] TIME_STEP_RESET = 16'd6554;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -24'sh800000;

  typedef struct packed {
    logic signed [24:0] dm;
    logic signed [24:0] dp;
    logic signed [25:0] g2;
  } axis_t;

  typedef struct packed {
    logic [SQ_W-1:0] x;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] c;
    logic [24:0]             n;
    logic                    pos;
    logic                    zero;
  } carry_t;

  typedef struct packed {
    logic [RT_W-1:0] rem;
    logic [Q_W-1:0]  q;
    logic [RT_W-1:0] d;
  } div_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] c;
    logic                    zero;
    logic                    gneg;
    logic [RT_W-1:0]         gmag;
    logic                    nlsb;
  } carry2_t;

  function automatic axis_t axis_diff(input logic signed [VAL_W-1:0] c,
                                      input logic signed [VAL_W-1:0] lo,
                                      input logic signed [VAL_W-1:0] hi,
                                      input logic first, input logic last);
    axis_t a;
    logic signed [24:0] c25, lo25, hi25;
    c25  = {c[VAL_W-1], c};
    lo25 = {lo[VAL_W-1], lo};
    hi25 = {hi[VAL_W-1], hi};
    if (first) begin
      a.dm = hi25 - c25;
      a.dp = a.dm;
      a.g2 = {a.dm, 1'b0};
    end else if (last) begin
      a.dm = c25 - lo25;
      a.dp = a.dm;
      a.g2 = {a.dm, 1'b0};
    end else begin
      a.dm = c25 - lo25;
      a.dp = hi25 - c25;
      a.g2 = {hi25[24], hi25} - {lo25[24], lo25};
    end
    return a;
  endfunction

  function automatic logic [24:0] mag25(input logic signed [24:0] v);
    logic [24:0] m;
    m = v[24] ? 25'(-v) : 25'(v);
    return m;
  endfunction

  function automatic logic [25:0] mag26(input logic signed [25:0] v);
    logic [25:0] m;
    m = v[25] ? 26'(-v) : 26'(v);
    return m;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s, input int k);
    sqrt_t o;
    logic [SQ_W-1:0] bv;
    logic [SQ_W:0]   trial;
    bv    = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    trial = {1'b0, s.r} + {1'b0, bv};
    if ({1'b0, s.x} >= trial) begin
      o.x = s.x - trial[SQ_W-1:0];
      o.r = (s.r >> 1) + bv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(input div_t s, input logic nbit);
    div_t o;
    logic [RT_W:0] t;
    t = {s.rem, nbit};
    o.d = s.d;
    if (t >= {1'b0, s.d}) begin
      o.rem = RT_W'(t - {1'b0, s.d});
      o.q   = {s.q[Q_W-2:0], 1'b1};
    end else begin
      o.rem = t[RT_W-1:0];
      o.q   = {s.q[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- sv/lsr_if.sv -----
// Stream and configuration channel interfaces of the level-set reinit step core.
`default_nettype none
interface lsr_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [23:0]       center_value;
  logic signed [23:0]       left_value;
  logic signed [23:0]       right_value;
  logic signed [23:0]       lower_value;
  logic signed [23:0]       upper_value;
  logic                     at_first_column;
  logic                     at_last_column;
  logic                     at_first_row;
  logic                     at_last_row;
  modport source(output valid, center_value, left_value, right_value, lower_value,
                 upper_value, at_first_column, at_last_column, at_first_row,
                 at_last_row, input ready);
  modport sink(input valid, center_value, left_value, right_value, lower_value,
               upper_value, at_first_column, at_last_column, at_first_row,
               at_last_row, output ready);
endinterface

interface lsr_out_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] new_value;
  modport source(output valid, new_value, input ready);
  modport sink(input valid, new_value, output ready);
endinterface

interface lsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] time_step;
  modport source(output valid, time_step, input ready);
  modport sink(input valid, time_step, output ready);
endinterface
`default_nettype wire

// ----- sv/level_set_reinit_step_core.sv -----
// Top level: pipelined level-set reinitialization update of one grid point per transfer.
// The core takes one stencil per cycle when the pipe advances and returns its updated
// value after the two 26-step square-root chains followed by the 17-step
// restoring divider for the sign factor, each step one register stage. The whole pipe
// advances together and holds while a finished result waits on out_ch.ready.
// time_step is written through cfg_ch and should change only while the pipe is empty.
`default_nettype none
module level_set_reinit_step_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lsr_in_if.sink     in_ch,
  lsr_out_if.source  out_ch,
  lsr_cfg_if.sink    cfg_ch
);

  localparam int NST    = 3 + lsr_pkg::SQRT_STEPS + 1 + lsr_pkg::DIV_STEPS + 3;
  localparam int VAL_W  = lsr_pkg::VAL_W;
  localparam int RT_W_L = lsr_pkg::RT_W;

  logic [lsr_pkg::TS_W-1:0] ts_r;
  logic [NST-1:0]           v_r;
  logic                     en;

  // stage 1
  lsr_pkg::axis_t      ax1_r, ay1_r;
  lsr_pkg::carry_t     k1_r;
  // stage 2
  logic [49:0]         a2_r;
  logic [51:0]         gxs2_r, gys2_r;
  logic [49:0]         u2_r [0:3];
  lsr_pkg::carry_t     k2_r;
  // square roots
  lsr_pkg::sqrt_t      ds_r [0:lsr_pkg::SQRT_STEPS];
  lsr_pkg::sqrt_t      us_r [0:lsr_pkg::SQRT_STEPS];
  lsr_pkg::carry_t     ks_r [0:lsr_pkg::SQRT_STEPS];
  // divider
  lsr_pkg::div_t       dv_r [0:lsr_pkg::DIV_STEPS];
  lsr_pkg::carry2_t    kd_r [0:lsr_pkg::DIV_STEPS];
  // tail
  logic [32:0]         p1_r;
  lsr_pkg::carry2_t    km1_r;
  logic [58:0]         p2_r;
  lsr_pkg::carry2_t    km2_r;
  logic signed [VAL_W-1:0] new_value_r;

  lsr_pkg::axis_t      ax, ay;
  logic signed [24:0]  ux0, ux1, uy0, uy1;
  logic signed [26:0]  g_nxt;
  logic [RT_W_L-1:0]   groot;
  logic [59:0]         rnd;
  logic [26:0]         rmag;
  logic signed [28:0]  term, res;
  logic signed [VAL_W-1:0] new_value_nxt;

  assign en           = !v_r[NST-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = v_r[NST-1];
  assign out_ch.new_value = new_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= lsr_pkg::TIME_STEP_RESET;
      v_r  <= '0;
    end else begin
      if (cfg_ch.valid) begin
        ts_r <= cfg_ch.time_step;
      end
      if (en) begin
        v_r <= {v_r[NST-2:0], in_ch.valid};
      end
    end
  end

  always_comb begin
    ax = lsr_pkg::axis_diff(in_ch.center_value, in_ch.left_value, in_ch.right_value,
                            in_ch.at_first_column, in_ch.at_last_column);
    ay = lsr_pkg::axis_diff(in_ch.center_value, in_ch.lower_value, in_ch.upper_value,
                            in_ch.at_first_row, in_ch.at_last_row);
    if (k1_r.pos) begin
      ux0 = ax1_r.dm[24] ? '0 : ax1_r.dm;
      ux1 = ax1_r.dp[24] ? ax1_r.dp : '0;
      uy0 = ay1_r.dm[24] ? '0 : ay1_r.dm;
      uy1 = ay1_r.dp[24] ? ay1_r.dp : '0;
    end else begin
      ux0 = ax1_r.dm[24] ? ax1_r.dm : '0;
      ux1 = ax1_r.dp[24] ? '0 : ax1_r.dp;
      uy0 = ay1_r.dm[24] ? ay1_r.dm : '0;
      uy1 = ay1_r.dp[24] ? '0 : ay1_r.dp;
    end
    groot = us_r[lsr_pkg::SQRT_STEPS].r[RT_W_L-1:0];
    g_nxt = $signed({1'b0, groot}) - 27'sd65536;
    rnd   = {1'b0, p2_r} + 60'(64'd1 << 31);
    rmag  = rnd[58:32];
    if (km2_r.zero) begin
      term = '0;
    end else if (km2_r.c[VAL_W-1] != km2_r.gneg) begin
      term = -$signed({2'b00, rmag});
    end else begin
      term = $signed({2'b00, rmag});
    end
    res = $signed({{5{km2_r.c[VAL_W-1]}}, km2_r.c}) - term;
    if (res > 29'(lsr_pkg::VAL_MAX)) begin
      new_value_nxt = lsr_pkg::VAL_MAX;
    end else if (res < 29'(lsr_pkg::VAL_MIN)) begin
      new_value_nxt = lsr_pkg::VAL_MIN;
    end else begin
      new_value_nxt = res[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r     <= ax;
      ay1_r     <= ay;
      k1_r.c    <= in_ch.center_value;
      k1_r.n    <= lsr_pkg::mag25({in_ch.center_value, 1'b0});
      k1_r.pos  <= !in_ch.center_value[VAL_W-1] && (in_ch.center_value != '0);
      k1_r.zero <= (in_ch.center_value == '0);

      a2_r   <= k1_r.n * k1_r.n;
      gxs2_r <= lsr_pkg::mag26(ax1_r.g2) * lsr_pkg::mag26(ax1_r.g2);
      gys2_r <= lsr_pkg::mag26(ay1_r.g2) * lsr_pkg::mag26(ay1_r.g2);
      u2_r[0] <= lsr_pkg::mag25(ux0) * lsr_pkg::mag25(ux0);
      u2_r[1] <= lsr_pkg::mag25(ux1) * lsr_pkg::mag25(ux1);
      u2_r[2] <= lsr_pkg::mag25(uy0) * lsr_pkg::mag25(uy0);
      u2_r[3] <= lsr_pkg::mag25(uy1) * lsr_pkg::mag25(uy1);
      k2_r   <= k1_r;

      ds_r[0].x <= {2'b00, a2_r} + gxs2_r + gys2_r;
      ds_r[0].r <= '0;
      us_r[0].x <= {2'b00, u2_r[0]} + {2'b00, u2_r[1]} + {2'b00, u2_r[2]}
                   + {2'b00, u2_r[3]};
      us_r[0].r <= '0;
      ks_r[0]   <= k2_r;
      for (int k = 0; k < lsr_pkg::SQRT_STEPS; k++) begin
        ds_r[k+1] <= lsr_pkg::sqrt_step(ds_r[k], k);
        us_r[k+1] <= lsr_pkg::sqrt_step(us_r[k], k);
        ks_r[k+1] <= ks_r[k];
      end

      dv_r[0].d    <= ds_r[lsr_pkg::SQRT_STEPS].r[RT_W_L-1:0];
      dv_r[0].rem  <= {2'b00, ks_r[lsr_pkg::SQRT_STEPS].n[24:1]};
      dv_r[0].q    <= '0;
      kd_r[0].c    <= ks_r[lsr_pkg::SQRT_STEPS].c;
      kd_r[0].zero <= ks_r[lsr_pkg::SQRT_STEPS].zero;
      kd_r[0].nlsb <= ks_r[lsr_pkg::SQRT_STEPS].n[0];
      kd_r[0].gneg <= g_nxt[26];
      kd_r[0].gmag <= g_nxt[26] ? RT_W_L'(-g_nxt) : g_nxt[RT_W_L-1:0];
      for (int j = 0; j < lsr_pkg::DIV_STEPS; j++) begin
        dv_r[j+1] <= lsr_pkg::div_step(dv_r[j], (j == 0) ? kd_r[j].nlsb : 1'b0);
        kd_r[j+1] <= kd_r[j];
      end

      p1_r  <= dv_r[lsr_pkg::DIV_STEPS].q * ts_r;
      km1_r <= kd_r[lsr_pkg::DIV_STEPS];
      p2_r  <= p1_r * km1_r.gmag;
      km2_r <= km1_r;
      new_value_r <= new_value_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench of the level-set reinit step core: directed stencils, then random ones.
module tb;

  typedef struct {
    logic signed [23:0] c, l, r, lo, up;
    logic fc, lc, fr, lr;
  } stencil_t;

  typedef struct {
    stencil_t st;
    logic has_exp;
    logic signed [23:0] exp_val;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  always #1 clk = ~clk;

  lsr_in_if in_ch();
  lsr_out_if out_ch();
  lsr_cfg_if cfg_ch();

  level_set_reinit_step_core i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
                                    .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink));

  logic [15:0] dt_model;
  logic signed [23:0] pending_values[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  longint cycles = 0;
  row_t dir_rows[$];
  logic [15:0] dt_list[5] = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd6554};

  function automatic longint isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void axis_calc(longint c, longint lo, longint hi, logic first,
                                    logic last, output longint dm, output longint dp,
                                    output longint g2);
    if (first) begin
      dm = hi - c; dp = dm; g2 = 2 * dm;
    end else if (last) begin
      dm = c - lo; dp = dm; g2 = 2 * dm;
    end else begin
      dm = c - lo; dp = hi - c; g2 = hi - lo;
    end
  endfunction

  function automatic logic signed [23:0] reinit_value(stencil_t s, logic [15:0] dt);
    longint c, dmx, dpx, gx2, dmy, dpy, gy2, g, term, res;
    longint unsigned den, smag, sum, e, t, rmag;
    c = s.c;
    axis_calc(c, s.l, s.r, s.fc, s.lc, dmx, dpx, gx2);
    axis_calc(c, s.lo, s.up, s.fr, s.lr, dmy, dpy, gy2);
    den = isqrt(4 * c * c + gx2 * gx2 + gy2 * gy2);
    smag = den != 0 ? (absl(2 * c) << 16) / den : 0;
    if (c > 0)
      sum = (dmx > 0 ? dmx * dmx : 0) + (dpx < 0 ? dpx * dpx : 0)
          + (dmy > 0 ? dmy * dmy : 0) + (dpy < 0 ? dpy * dpy : 0);
    else
      sum = (dmx < 0 ? dmx * dmx : 0) + (dpx > 0 ? dpx * dpx : 0)
          + (dmy < 0 ? dmy * dmy : 0) + (dpy > 0 ? dpy * dpy : 0);
    e = isqrt(sum);
    g = longint'(e) - 65536;
    t = smag * longint'(absl(g)) * longint'(dt);
    rmag = (t + (64'd1 << 31)) >> 32;
    term = ((c < 0) != (g < 0)) ? -longint'(rmag) : longint'(rmag);
    if (smag == 0) term = 0;
    res = c - term;
    if (res > 8388607) res = 8388607;
    if (res < -8388608) res = -8388608;
    return res[23:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("level_set_reinit_step_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_values.size() == 0) begin
        report_mismatch("unexpected transfer", out_ch.new_value, 0);
      end else begin
        if (out_ch.new_value !== pending_values[0])
          report_mismatch("new_value", out_ch.new_value, pending_values[0]);
        void'(pending_values.pop_front());
      end
    end
  end

  task automatic send_stencil(stencil_t s, logic has_exp, logic signed [23:0] want);
    logic signed [23:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    pred = reinit_value(s, dt_model);
    if (has_exp && pred !== want) report_mismatch("directed table", pred, want);
    in_ch.valid <= 1;
    in_ch.center_value <= s.c;
    in_ch.left_value <= s.l;
    in_ch.right_value <= s.r;
    in_ch.lower_value <= s.lo;
    in_ch.upper_value <= s.up;
    in_ch.at_first_column <= s.fc;
    in_ch.at_last_column <= s.lc;
    in_ch.at_first_row <= s.fr;
    in_ch.at_last_row <= s.lr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_values.insert(pending_values.size(), has_exp ? want : pred);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_time_step(logic [15:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.time_step <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    dt_model = v;
  endtask

  function automatic logic signed [23:0] rand_val(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(131072))) - 24'sd65536;
      default: return $signed(24'($urandom_range(2097152))) - 24'sd1048576;
    endcase
  endfunction

  function automatic stencil_t rand_stencil();
    stencil_t s;
    int mode;
    longint slope;
    mode = $urandom_range(9);
    s.fc = ($urandom_range(7) == 0);
    s.lc = ($urandom_range(7) == 0);
    s.fr = ($urandom_range(7) == 0);
    s.lr = ($urandom_range(7) == 0);
    if (mode < 6) begin
      // smooth field near a distance function
      s.c = rand_val(2);
      slope = $urandom_range(131072);
      s.l = 24'(s.c - slope + $urandom_range(8192) - 4096);
      s.r = 24'(s.c + slope + $urandom_range(8192) - 4096);
      slope = $urandom_range(131072);
      s.lo = 24'(s.c - slope + $urandom_range(8192) - 4096);
      s.up = 24'(s.c + slope + $urandom_range(8192) - 4096);
    end else begin
      s.c = (mode == 9) ? 24'sd0 : rand_val(mode == 6 ? 0 : 1);
      s.l = rand_val(mode - 6);
      s.r = rand_val(mode - 6);
      s.lo = rand_val(mode - 6);
      s.up = rand_val(mode - 6);
    end
    return s;
  endfunction

  function automatic row_t mk(longint c, longint l, longint r, longint lo, longint up,
                              logic [3:0] f, logic has_exp, longint want);
    row_t t;
    t.st.c = 24'(c); t.st.l = 24'(l); t.st.r = 24'(r);
    t.st.lo = 24'(lo); t.st.up = 24'(up);
    {t.st.fc, t.st.lc, t.st.fr, t.st.lr} = f;
    t.has_exp = has_exp;
    t.exp_val = 24'(want);
    return t;
  endfunction

  task automatic add_row(row_t t);
    dir_rows.insert(dir_rows.size(), t);
  endtask

  task automatic run_random(int n);
    repeat (n) send_stencil(rand_stencil(), 0, 0);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.center_value = 0; in_ch.left_value = 0; in_ch.right_value = 0;
    in_ch.lower_value = 0; in_ch.upper_value = 0;
    in_ch.at_first_column = 0; in_ch.at_last_column = 0;
    in_ch.at_first_row = 0; in_ch.at_last_row = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.time_step = 0;
    dt_model = lsr_pkg::TIME_STEP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    add_row(mk(0, 0, 0, 0, 0, 4'b0000, 1, 0));
    add_row(mk(0, 8388607, -8388608, 8388607, -8388608, 4'b0000, 1, 0));
    add_row(mk(0, 0, 0, 0, 0, 4'b1111, 1, 0));
    add_row(mk(65536, 0, 131072, 0, 131072, 4'b0000, 0, 0));
    add_row(mk(-65536, 0, -131072, 0, -131072, 4'b0000, 0, 0));
    add_row(mk(8388607, 8388607, 8388607, 8388607, 8388607, 4'b0000, 0, 0));
    add_row(mk(-8388608, -8388608, -8388608, -8388608, -8388608, 4'b0000, 0, 0));
    add_row(mk(8388607, -8388608, -8388608, -8388608, -8388608, 4'b0000, 0, 0));
    add_row(mk(-8388608, 8388607, 8388607, 8388607, 8388607, 4'b0000, 0, 0));
    add_row(mk(1, 0, 0, 0, 0, 4'b0000, 0, 0));
    add_row(mk(-1, 0, 0, 0, 0, 4'b0000, 0, 0));
    add_row(mk(1000, 5, 2000, -300, 4000, 4'b1000, 0, 0));
    add_row(mk(1000, 5, 2000, -300, 4000, 4'b0100, 0, 0));
    add_row(mk(1000, 5, 2000, -300, 4000, 4'b0010, 0, 0));
    add_row(mk(1000, 5, 2000, -300, 4000, 4'b0001, 0, 0));
    add_row(mk(-70000, 5, 2000, -300, 4000, 4'b1100, 0, 0));
    add_row(mk(-70000, 5, 2000, -300, 4000, 4'b0011, 0, 0));
    add_row(mk(-70000, 5, 2000, -300, 4000, 4'b1111, 0, 0));
    add_row(mk(300000, -8388608, 8388607, 0, 0, 4'b0000, 0, 0));
    foreach (dir_rows[i]) send_stencil(dir_rows[i].st, dir_rows[i].has_exp,
                                       dir_rows[i].exp_val);
    drain();

    foreach (dt_list[k]) begin
      write_time_step(dt_list[k]);
      send_idle_pct = 17; recv_idle_pct = 53;
      run_random(100);
      send_idle_pct = 53; recv_idle_pct = 17;
      run_random(100);
      send_idle_pct = 0; recv_idle_pct = 0;
      if (k == 1) begin
        hold_off <= 300;
        run_random(150);
        drain();
      end
      run_random(100);
      drain();
    end

    drain();
    if (errors == 0)
      $display("level_set_reinit_step_core test passed");
    else
      $display("level_set_reinit_step_core test failed");
    $finish;
  end
endmodule
